// ----- hw/rtl/sefc_pkg.sv -----
// Shared constants, types and the CRC-32C byte step for the evidence frame check.
package sefc_pkg;

    localparam int unsigned FrameLen  = 36;
    localparam int unsigned AckLen    = 64;
    localparam logic [31:0] CrcPoly   = 32'h82F6_3B78;
    localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
    localparam logic [9:0]  AgeLimit  = 10'd1000;
    localparam logic [31:0] HalfRange = 32'h8000_0000;
    localparam logic [7:0]  FlagMask  = 8'h07;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_FRESH  = 2'd2;

    localparam logic [0:0] REG_BOOT_ID = 1'b0;
    localparam logic [0:0] REG_MAX_AGE = 1'b1;

    // Ack fields handed from the top-level frame check to the ack sender.
    typedef struct packed {
        logic [31:0] sequence_no;
        logic [31:0] boot;
        logic [31:0] now;
        logic [31:0] observed;
        logic [2:0]  flags;
    } ack_info_t;

    // One result beat.
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] out_byte;
        logic       is_fresh;
        logic       last;
    } beat_t;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/sefc_ack_tx.sv -----
// Ack frame sender: builds the 64-byte acknowledgement one byte per beat with running CRC.
module sefc_ack_tx
    import sefc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ack_info_t info,
    input  logic      take,
    output logic      busy,
    output logic [7:0] tx_byte,
    output logic      tx_last
);

    logic       busy_reg, busy_next;
    logic [5:0] idx_reg, idx_next;
    logic [31:0] crc_reg, crc_next;
    ack_info_t  info_reg, info_next;
    logic [31:0] crc_out;
    logic [7:0] b;

    assign crc_out = crc_reg ^ CrcInit;

    always_comb
    begin
        case (idx_reg)
            6'd0: b = 8'h41;
            6'd1: b = 8'h46;
            6'd2, 6'd3: b = 8'h01;
            6'd4: b = info_reg.sequence_no[7:0];
            6'd5: b = info_reg.sequence_no[15:8];
            6'd6: b = info_reg.sequence_no[23:16];
            6'd7: b = info_reg.sequence_no[31:24];
            6'd8: b = info_reg.boot[7:0];
            6'd9: b = info_reg.boot[15:8];
            6'd10: b = info_reg.boot[23:16];
            6'd11: b = info_reg.boot[31:24];
            6'd12: b = info_reg.now[7:0];
            6'd13: b = info_reg.now[15:8];
            6'd14: b = info_reg.now[23:16];
            6'd15: b = info_reg.now[31:24];
            6'd16: b = info_reg.observed[7:0];
            6'd17: b = info_reg.observed[15:8];
            6'd18: b = info_reg.observed[23:16];
            6'd19: b = info_reg.observed[31:24];
            6'd20: b = {5'd0, info_reg.flags};
            6'd60: b = crc_out[7:0];
            6'd61: b = crc_out[15:8];
            6'd62: b = crc_out[23:16];
            6'd63: b = crc_out[31:24];
            default: b = 8'h00;
        endcase
    end

    assign busy    = busy_reg;
    assign tx_byte = b;
    assign tx_last = (idx_reg == 6'(AckLen - 1));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        info_next = info_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            crc_next  = CrcInit;
            info_next = info;
        end
        else if (busy_reg && take)
        begin
            idx_next = idx_reg + 6'd1;
            if (idx_reg < 6'd60)
            begin
                crc_next = crc_step(crc_reg, b);
            end
            if (tx_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            crc_reg  <= CrcInit;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

endmodule

// ----- hw/rtl/sequenced_evidence_frame_check.sv -----
// Top level of the sequenced evidence frame check.
//
//  channel | signals                                   | accepted when
//  in      | in_valid/in_stall, kind..now_ms           | in_valid && !in_stall
//  out     | out_valid/out_stall, result_kind..last    | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data               | cfg_we
//
// Request bytes do not wait on one another: CRC step and field capture sit
// between the input beat and the frame state registers. Byte 35 of a
// rejected frame (or a query) puts one result beat in the output register;
// an accepted frame sends 64 ack beats from the ack sender instead, which
// holds input (in_stall) while busy. The output register is a skid stage:
// input stays open while a result waits, unless a second result is needed.
// Reset (rst_n low, async) re-arms the receiver and clears stored evidence.
module sequenced_evidence_frame_check
    import sefc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic        frame_start,
    input  logic [7:0]  data_byte,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  out_byte,
    output logic        is_fresh,
    output logic        last
);

    logic [31:0] boot_id_reg;
    logic [9:0]  max_age_reg;

    logic [5:0]  pos_reg;
    logic [31:0] crc_reg;
    logic        hdr_ok_reg;
    logic [31:0] rx_seq_reg, rx_boot_reg, rx_obs_reg, rx_exp_reg, rx_chk_reg;
    logic [7:0]  rx_flags_reg;
    logic [31:0] last_seq_reg, last_obs_reg, exp_time_reg;
    logic        ev_valid_reg;

    // single result register (reject / freshness beats)
    logic        ov_reg;
    beat_t       ob_reg;

    logic        ack_busy, ack_start, ack_last;
    logic [7:0]  ack_byte;
    ack_info_t   ack_info;

    logic        acc, out_take, done;
    logic [5:0]  pos;
    logic [31:0] crc_cur, crc_fin, dn, de, dw, adv, left;
    logic        ok1, ok, fresh;

    assign out_take = out_valid && !out_stall;
    // a result-making beat needs the result register empty or being emptied;
    // no beat enters while an ack is in flight
    assign in_stall = ack_busy
                      || (ov_reg && out_stall && (kind || (pos == 6'(FrameLen - 1))));
    assign acc      = in_valid && !in_stall;

    assign pos     = frame_start ? 6'd0 : pos_reg;
    assign crc_cur = frame_start ? CrcInit : crc_reg;
    assign done    = acc && !kind && (pos == 6'(FrameLen - 1));

    // final check; byte 35 completes the check word
    assign crc_fin = crc_cur ^ CrcInit;
    assign dn  = now_ms - rx_obs_reg;
    assign de  = rx_exp_reg - now_ms;
    assign dw  = rx_exp_reg - rx_obs_reg;
    assign adv = rx_obs_reg - last_obs_reg;
    assign ok1 = (boot_id_reg != 0) && (max_age_reg != 0) && (max_age_reg <= AgeLimit)
                 && (frame_start || hdr_ok_reg)
                 && ({data_byte, rx_chk_reg[31:8]} == crc_fin);
    assign ok  = ok1 && (rx_seq_reg != 0) && (rx_seq_reg > last_seq_reg)
                 && (rx_boot_reg == boot_id_reg) && ((rx_flags_reg & ~FlagMask) == 8'd0)
                 && (dn < {22'd0, max_age_reg}) && (de != 0) && (de <= {22'd0, max_age_reg})
                 && (dw <= {22'd0, max_age_reg})
                 && ((last_seq_reg == 0) || ((adv != 0) && (adv < HalfRange)));

    assign left  = exp_time_reg - now_ms;
    assign fresh = ev_valid_reg && (max_age_reg != 0) && ((now_ms - last_obs_reg)
                   < {22'd0, max_age_reg}) && (left != 0) && (left < HalfRange);

    // stored flags travel with the ack info; the sender keeps its own copy
    assign ack_start = done && ok;
    assign ack_info  = '{sequence_no: rx_seq_reg, boot: boot_id_reg, now: now_ms,
                         observed: rx_obs_reg, flags: rx_flags_reg[2:0]};

    sefc_ack_tx u_ack (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ack_start),
        .info    (ack_info),
        .take    (!out_stall && !ov_reg),
        .busy    (ack_busy),
        .tx_byte (ack_byte),
        .tx_last (ack_last)
    );

    assign out_valid   = ov_reg || ack_busy;
    assign result_kind = ov_reg ? ob_reg.result_kind : KIND_ACK;
    assign out_byte    = ov_reg ? ob_reg.out_byte : ack_byte;
    assign is_fresh    = ov_reg ? ob_reg.is_fresh : 1'b0;
    assign last        = ov_reg ? ob_reg.last : ack_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_id_reg  <= '0;
            max_age_reg  <= '0;
            pos_reg      <= '0;
            crc_reg      <= CrcInit;
            hdr_ok_reg   <= 1'b1;
            rx_seq_reg   <= '0;
            rx_boot_reg  <= '0;
            rx_obs_reg   <= '0;
            rx_exp_reg   <= '0;
            rx_chk_reg   <= '0;
            rx_flags_reg <= '0;
            last_seq_reg <= '0;
            last_obs_reg <= '0;
            exp_time_reg <= '0;
            ev_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
            ob_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BOOT_ID: boot_id_reg <= cfg_data;
                    REG_MAX_AGE: max_age_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (out_take && ov_reg)
            begin
                ov_reg <= 1'b0;
            end
            if (acc && kind)
            begin
                ov_reg <= 1'b1;
                ob_reg <= '{result_kind: KIND_FRESH, out_byte: 8'd0, is_fresh: fresh, last: 1'b1};
            end
            else if (acc)
            begin
                // field capture
                if (pos < 6'd4)
                begin
                    if (data_byte != ((pos == 6'd0) ? 8'h41 : (pos == 6'd1) ? 8'h45 : 8'h01))
                    begin
                        hdr_ok_reg <= 1'b0;
                    end
                    else
                    begin
                        hdr_ok_reg <= frame_start ? 1'b1 : hdr_ok_reg;
                    end
                end
                else if (pos < 6'd8)  rx_seq_reg  <= {data_byte, rx_seq_reg[31:8]};
                else if (pos < 6'd12) rx_boot_reg <= {data_byte, rx_boot_reg[31:8]};
                else if (pos < 6'd16) rx_obs_reg  <= {data_byte, rx_obs_reg[31:8]};
                else if (pos < 6'd20) rx_exp_reg  <= {data_byte, rx_exp_reg[31:8]};
                else if (pos == 6'd20) rx_flags_reg <= data_byte;
                else if (pos < 6'd32)
                begin
                    if (data_byte != 8'd0) hdr_ok_reg <= 1'b0;
                end
                else rx_chk_reg <= {data_byte, rx_chk_reg[31:8]};

                if (pos < 6'd32) crc_reg <= crc_step(crc_cur, data_byte);
                else crc_reg <= crc_cur;

                if (done)
                begin
                    pos_reg    <= '0;
                    crc_reg    <= CrcInit;
                    hdr_ok_reg <= 1'b1;
                    if (ok)
                    begin
                        last_seq_reg <= rx_seq_reg;
                        last_obs_reg <= rx_obs_reg;
                        exp_time_reg <= rx_exp_reg;
                        ev_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        ov_reg <= 1'b1;
                        ob_reg <= '{result_kind: KIND_REJECT, out_byte: 8'd0,
                                    is_fresh: 1'b0, last: 1'b1};
                    end
                end
                else
                begin
                    pos_reg <= pos + 6'd1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/sefc_checker.sv -----
// Port-level checker for the evidence frame check, bound to the top level.
module sefc_checker
    import sefc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       kind,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] result_kind,
    input logic [7:0] out_byte,
    input logic       is_fresh,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(result_kind))
        else $error("stalled result changed");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind == KIND_ACK || result_kind == KIND_REJECT
                      || result_kind == KIND_FRESH)
        else $error("bad result kind");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_ACK |-> last && out_byte == 8'd0)
        else $error("reject or freshness beat not single");

    a_fresh_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_fresh |-> result_kind == KIND_FRESH)
        else $error("is_fresh outside freshness answer");

    a_query_answer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind |=> out_valid)
        else $error("query without answer");

endmodule

bind sequenced_evidence_frame_check sefc_checker u_sefc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .out_byte    (out_byte),
    .is_fresh    (is_fresh),
    .last        (last)
);
